@@ rtl/core/r2c_pkg.sv @@
// Package for the RGB to CMYK converter: field widths, color codes, constant-divide helpers.
package r2c_pkg;

    localparam int PIX_W    = 8;
    localparam int TENTHS_W = 4;
    localparam int PCT_W    = 7;
    localparam int NAME_W   = 4;

    // Codes for the eight pure named colors
    typedef enum logic [NAME_W-1:0] {
        CN_NONE    = 4'd0,
        CN_BLACK   = 4'd1,
        CN_WHITE   = 4'd2,
        CN_RED     = 4'd3,
        CN_GREEN   = 4'd4,
        CN_BLUE    = 4'd5,
        CN_CYAN    = 4'd6,
        CN_YELLOW  = 4'd7,
        CN_MAGENTA = 4'd8
    } t_color_name;

    // First estimate of x/255 for x < 2^15: floor(x*257/2^16), low by at most one
    function automatic logic [PCT_W-1:0] div255_est(input logic [14:0] x);
        logic [22:0] p;
        p = {8'd0, x} + ({8'd0, x} << 8);
        return p[22:16];
    endfunction

    // Correct the estimate: add one if the remainder still reaches 255
    function automatic logic [PCT_W-1:0] div255_fix(input logic [14:0] x,
                                                    input logic [PCT_W-1:0] q0);
        logic [14:0] qm;
        logic [14:0] rem;
        qm  = ({8'd0, q0} << 8) - {8'd0, q0};
        rem = x - qm;
        return q0 + PCT_W'(rem >= 15'd255);
    endfunction

endpackage

@@ rtl/core/r2c_if.sv @@
// Channel interfaces of the converter: pixel in, converted color out.
interface r2c_pix_if import r2c_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface r2c_res_if import r2c_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [TENTHS_W-1:0] red_tenths;
    logic [TENTHS_W-1:0] green_tenths;
    logic [TENTHS_W-1:0] blue_tenths;
    logic [PCT_W-1:0]    red_percent;
    logic [PCT_W-1:0]    green_percent;
    logic [PCT_W-1:0]    blue_percent;
    logic [PCT_W-1:0]    cyan_percent;
    logic [PCT_W-1:0]    magenta_percent;
    logic [PCT_W-1:0]    yellow_percent;
    logic [PCT_W-1:0]    key_percent;
    logic [NAME_W-1:0]   color_name;

    modport source (output valid, output red_tenths, output green_tenths, output blue_tenths,
                    output red_percent, output green_percent, output blue_percent,
                    output cyan_percent, output magenta_percent, output yellow_percent,
                    output key_percent, output color_name, input ready);
    modport sink   (input valid, input red_tenths, input green_tenths, input blue_tenths,
                    input red_percent, input green_percent, input blue_percent,
                    input cyan_percent, input magenta_percent, input yellow_percent,
                    input key_percent, input color_name, output ready);
endinterface

@@ rtl/core/rgb_to_cmyk_converter.sv @@
// Top level of the RGB to CMYK converter: six-stage pipeline, one pixel per clock unless stalled.
//
// Converts one 8-bit RGB pixel into rounded tenths and floor percent per channel,
// CMYK ink percentages and a code for the eight pure colors. A new pixel is taken
// every clock while the pipeline can advance; each result passes through the six
// register stages (input, max/numerators, then four stages of the per-channel
// restoring divider for C/M/Y, two quotient bits each but the last, which holds one
// bit and is the output register). A stall on the output holds every stage that is
// full; empty stages still fill, so the input keeps taking pixels until the whole
// pipeline is occupied. Pure black gives C = M = Y = 0 and K = 100. No reset-time sweep,
// no state kept between pixels.
module rgb_to_cmyk_converter import r2c_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    r2c_pix_if.sink      i_pix,
    r2c_res_if.source    o_res
);

    // Restoring division step: compare against den << sh, return {quotient bit, remainder}
    function automatic logic [16:0] ink_step(input logic [15:0] rem,
                                             input logic [8:0]  den,
                                             input int unsigned sh);
        logic [15:0] dsh;
        dsh = {7'd0, den} << sh;
        if (rem >= dsh) begin
            return {1'b1, rem - dsh};
        end
        return {1'b0, rem};
    endfunction

    // Stage valids and advance enables
    logic r_v0, r_v1, r_v2, r_v3, r_v4, r_v5;
    logic w_en0, w_en1, w_en2, w_en3, w_en4, w_en5;

    assign w_en5 = !r_v5 || o_res.ready;
    assign w_en4 = !r_v4 || w_en5;
    assign w_en3 = !r_v3 || w_en4;
    assign w_en2 = !r_v2 || w_en3;
    assign w_en1 = !r_v1 || w_en2;
    assign w_en0 = !r_v0 || w_en1;
    assign i_pix.ready = w_en0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (w_en0) r_v0 <= i_pix.valid;
            if (w_en1) r_v1 <= r_v0;
            if (w_en2) r_v2 <= r_v1;
            if (w_en3) r_v3 <= r_v2;
            if (w_en4) r_v4 <= r_v3;
            if (w_en5) r_v5 <= r_v4;
        end
    end

    // Stage 0: input register
    logic [PIX_W-1:0] r_ch0 [3];

    always_ff @(posedge i_clk) begin
        if (w_en0) begin
            r_ch0[0] <= i_pix.red;
            r_ch0[1] <= i_pix.green;
            r_ch0[2] <= i_pix.blue;
        end
    end

    // Stage 1: max channel, numerators, color name
    logic [11:0]       r_tx1   [3];
    logic [14:0]       r_px1   [3];
    logic [15:0]       r_rem1  [3];
    logic [14:0]       r_kx1;
    logic [8:0]        r_den1;
    logic              r_mz1;
    t_color_name       r_name1;

    logic [11:0]       n_tx1   [3];
    logic [14:0]       n_px1   [3];
    logic [15:0]       n_rem1  [3];
    logic [14:0]       n_kx1;
    logic [PIX_W-1:0]  w_mx;
    logic [12:0]       w_t13   [3];
    logic [15:0]       w_k16;
    t_color_name       n_name1;

    always_comb begin
        w_mx = r_ch0[0];
        if (r_ch0[1] > w_mx) w_mx = r_ch0[1];
        if (r_ch0[2] > w_mx) w_mx = r_ch0[2];
        for (int i = 0; i < 3; i++) begin
            w_t13[i]  = 13'(r_ch0[i]) * 13'd20 + 13'd255;
            n_tx1[i]  = w_t13[i][12:1];
            n_px1[i]  = 15'(r_ch0[i]) * 15'd100;
            n_rem1[i] = 16'(w_mx - r_ch0[i]) * 16'd200 + 16'(w_mx);
        end
        w_k16 = 16'(8'd255 - w_mx) * 16'd200 + 16'd255;
        n_kx1 = w_k16[15:1];
        case ({r_ch0[0], r_ch0[1], r_ch0[2]})
            24'h000000: n_name1 = CN_BLACK;
            24'hFFFFFF: n_name1 = CN_WHITE;
            24'hFF0000: n_name1 = CN_RED;
            24'h00FF00: n_name1 = CN_GREEN;
            24'h0000FF: n_name1 = CN_BLUE;
            24'h00FFFF: n_name1 = CN_CYAN;
            24'hFFFF00: n_name1 = CN_YELLOW;
            24'hFF00FF: n_name1 = CN_MAGENTA;
            default:    n_name1 = CN_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_tx1   <= n_tx1;
            r_px1   <= n_px1;
            r_rem1  <= n_rem1;
            r_kx1   <= n_kx1;
            r_den1  <= {w_mx, 1'b0};
            r_mz1   <= (w_mx == '0);
            r_name1 <= n_name1;
        end
    end

    // Stage 2: divide-by-255 estimates, ink quotient bits 6 and 5
    logic [14:0]       r_tx2  [3];
    logic [14:0]       r_px2  [3];
    logic [PCT_W-1:0]  r_tq2  [3];
    logic [PCT_W-1:0]  r_pq2  [3];
    logic [14:0]       r_kx2;
    logic [PCT_W-1:0]  r_kq2;
    logic [15:0]       r_rem2 [3];
    logic [PCT_W-1:0]  r_q2   [3];
    logic [8:0]        r_den2;
    logic              r_mz2;
    t_color_name       r_name2;

    logic [15:0]       n_rem2 [3];
    logic [PCT_W-1:0]  n_q2   [3];
    logic [16:0]       w_s2a  [3];
    logic [16:0]       w_s2b  [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_s2a[i]  = ink_step(r_rem1[i], r_den1, 6);
            w_s2b[i]  = ink_step(w_s2a[i][15:0], r_den1, 5);
            n_rem2[i] = w_s2b[i][15:0];
            n_q2[i]   = {w_s2a[i][16], w_s2b[i][16], 5'd0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            for (int i = 0; i < 3; i++) begin
                r_tx2[i] <= 15'(r_tx1[i]);
                r_px2[i] <= r_px1[i];
                r_tq2[i] <= div255_est(15'(r_tx1[i]));
                r_pq2[i] <= div255_est(r_px1[i]);
            end
            r_kx2   <= r_kx1;
            r_kq2   <= div255_est(r_kx1);
            r_rem2  <= n_rem2;
            r_q2    <= n_q2;
            r_den2  <= r_den1;
            r_mz2   <= r_mz1;
            r_name2 <= r_name1;
        end
    end

    // Stage 3: estimate corrections, ink quotient bits 4 and 3
    logic [TENTHS_W-1:0] r_ten3 [3];
    logic [PCT_W-1:0]    r_pct3 [3];
    logic [PCT_W-1:0]    r_key3;
    logic [15:0]         r_rem3 [3];
    logic [PCT_W-1:0]    r_q3   [3];
    logic [8:0]          r_den3;
    logic                r_mz3;
    t_color_name         r_name3;

    logic [PCT_W-1:0]    w_tfix [3];
    logic [15:0]         n_rem3 [3];
    logic [PCT_W-1:0]    n_q3   [3];
    logic [16:0]         w_s3a  [3];
    logic [16:0]         w_s3b  [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_tfix[i] = div255_fix(r_tx2[i], r_tq2[i]);
            w_s3a[i]  = ink_step(r_rem2[i], r_den2, 4);
            w_s3b[i]  = ink_step(w_s3a[i][15:0], r_den2, 3);
            n_rem3[i] = w_s3b[i][15:0];
            n_q3[i]   = r_q2[i] | {2'd0, w_s3a[i][16], w_s3b[i][16], 3'd0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            for (int i = 0; i < 3; i++) begin
                r_ten3[i] <= w_tfix[i][TENTHS_W-1:0];
                r_pct3[i] <= div255_fix(r_px2[i], r_pq2[i]);
            end
            r_key3  <= div255_fix(r_kx2, r_kq2);
            r_rem3  <= n_rem3;
            r_q3    <= n_q3;
            r_den3  <= r_den2;
            r_mz3   <= r_mz2;
            r_name3 <= r_name2;
        end
    end

    // Stage 4: ink quotient bits 2 and 1
    logic [TENTHS_W-1:0] r_ten4 [3];
    logic [PCT_W-1:0]    r_pct4 [3];
    logic [PCT_W-1:0]    r_key4;
    logic [15:0]         r_rem4 [3];
    logic [PCT_W-1:0]    r_q4   [3];
    logic [8:0]          r_den4;
    logic                r_mz4;
    t_color_name         r_name4;

    logic [15:0]         n_rem4 [3];
    logic [PCT_W-1:0]    n_q4   [3];
    logic [16:0]         w_s4a  [3];
    logic [16:0]         w_s4b  [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_s4a[i]  = ink_step(r_rem3[i], r_den3, 2);
            w_s4b[i]  = ink_step(w_s4a[i][15:0], r_den3, 1);
            n_rem4[i] = w_s4b[i][15:0];
            n_q4[i]   = r_q3[i] | {4'd0, w_s4a[i][16], w_s4b[i][16], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en4) begin
            r_ten4  <= r_ten3;
            r_pct4  <= r_pct3;
            r_key4  <= r_key3;
            r_rem4  <= n_rem4;
            r_q4    <= n_q4;
            r_den4  <= r_den3;
            r_mz4   <= r_mz3;
            r_name4 <= r_name3;
        end
    end

    // Stage 5: last quotient bit, black override, output register
    logic [TENTHS_W-1:0] r_ten5 [3];
    logic [PCT_W-1:0]    r_pct5 [3];
    logic [PCT_W-1:0]    r_ink5 [3];
    logic [PCT_W-1:0]    r_key5;
    t_color_name         r_name5;

    logic [PCT_W-1:0]    n_ink5 [3];
    logic [16:0]         w_s5   [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_s5[i]   = ink_step(r_rem4[i], r_den4, 0);
            n_ink5[i] = r_mz4 ? '0 : (r_q4[i] | {6'd0, w_s5[i][16]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en5) begin
            r_ten5  <= r_ten4;
            r_pct5  <= r_pct4;
            r_ink5  <= n_ink5;
            r_key5  <= r_key4;
            r_name5 <= r_name4;
        end
    end

    // Output drive
    assign o_res.valid           = r_v5;
    assign o_res.red_tenths      = r_ten5[0];
    assign o_res.green_tenths    = r_ten5[1];
    assign o_res.blue_tenths     = r_ten5[2];
    assign o_res.red_percent     = r_pct5[0];
    assign o_res.green_percent   = r_pct5[1];
    assign o_res.blue_percent    = r_pct5[2];
    assign o_res.cyan_percent    = r_ink5[0];
    assign o_res.magenta_percent = r_ink5[1];
    assign o_res.yellow_percent  = r_ink5[2];
    assign o_res.key_percent     = r_key5;
    assign o_res.color_name      = r_name5;

endmodule

@@ rtl/core/r2c_checker.sv @@
// Port-level checker for the RGB to CMYK converter and its bind to the top level.
module r2c_checker import r2c_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                i_ready,
    input logic [PCT_W-1:0]    i_cyan,
    input logic [PCT_W-1:0]    i_magenta,
    input logic [PCT_W-1:0]    i_yellow,
    input logic [PCT_W-1:0]    i_key,
    input logic [NAME_W-1:0]   i_name
);

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_valid)
        else $error("result valid right after reset");

    // A stalled result stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid)
        else $error("result dropped while stalled");

    // The largest channel always needs no ink
    a_max_no_ink: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_cyan == '0 || i_magenta == '0 || i_yellow == '0))
        else $error("no ink channel at zero");

    // Pure black is full key and no color ink
    a_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_name == CN_BLACK |->
            i_key == PCT_W'(100) && i_cyan == '0 && i_magenta == '0 && i_yellow == '0)
        else $error("black pixel with wrong inks");

endmodule

bind rgb_to_cmyk_converter r2c_checker u_r2c_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_valid   (o_res.valid),
    .i_ready   (o_res.ready),
    .i_cyan    (o_res.cyan_percent),
    .i_magenta (o_res.magenta_percent),
    .i_yellow  (o_res.yellow_percent),
    .i_key     (o_res.key_percent),
    .i_name    (o_res.color_name)
);

@@ test/r2c_color_checker.sv @@
// Checker for the RGB to CMYK converter: predicts every converted color and compares it.
`timescale 1ns / 100ps

module r2c_color_checker import r2c_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    r2c_pix_if   i_pix,
    r2c_res_if   i_res,
    output int   o_fail_count,
    output int   o_pending
);

    // All forms of one pixel's color, as the block should return them
    typedef struct {
        logic [TENTHS_W-1:0] red_tenths;
        logic [TENTHS_W-1:0] green_tenths;
        logic [TENTHS_W-1:0] blue_tenths;
        logic [PCT_W-1:0]    red_percent;
        logic [PCT_W-1:0]    green_percent;
        logic [PCT_W-1:0]    blue_percent;
        logic [PCT_W-1:0]    cyan_percent;
        logic [PCT_W-1:0]    magenta_percent;
        logic [PCT_W-1:0]    yellow_percent;
        logic [PCT_W-1:0]    key_percent;
        t_color_name         color_name;
    } t_color_forms;

    t_color_forms color_forms_q [$];
    t_color_forms want;
    int           fail_total = 0;

    // Rounded tenths of full scale; never lands on a half
    function automatic logic [TENTHS_W-1:0] tenths_of(input int unsigned v);
        return TENTHS_W'((20 * v + 255) / 510);
    endfunction

    // Whole percent, truncated
    function automatic logic [PCT_W-1:0] percent_of(input int unsigned v);
        return PCT_W'((100 * v) / 255);
    endfunction

    // Ink relative to the largest channel, halves round up, zero for black
    function automatic logic [PCT_W-1:0] ink_of(input int unsigned mx, input int unsigned v);
        if (mx == 0) begin
            return '0;
        end
        return PCT_W'((200 * (mx - v) + mx) / (2 * mx));
    endfunction

    function automatic t_color_forms predict_forms(input logic [PIX_W-1:0] r,
                                                   input logic [PIX_W-1:0] g,
                                                   input logic [PIX_W-1:0] b);
        t_color_forms f;
        int unsigned  mx;
        mx = r;
        if (g > mx) begin
            mx = g;
        end
        if (b > mx) begin
            mx = b;
        end
        f.red_tenths      = tenths_of(r);
        f.green_tenths    = tenths_of(g);
        f.blue_tenths     = tenths_of(b);
        f.red_percent     = percent_of(r);
        f.green_percent   = percent_of(g);
        f.blue_percent    = percent_of(b);
        f.cyan_percent    = ink_of(mx, r);
        f.magenta_percent = ink_of(mx, g);
        f.yellow_percent  = ink_of(mx, b);
        f.key_percent     = PCT_W'((200 * (255 - mx) + 255) / 510);
        // Only exact 0/255 patterns carry a name
        case ({r, g, b})
            24'h000000: f.color_name = CN_BLACK;
            24'hFFFFFF: f.color_name = CN_WHITE;
            24'hFF0000: f.color_name = CN_RED;
            24'h00FF00: f.color_name = CN_GREEN;
            24'h0000FF: f.color_name = CN_BLUE;
            24'h00FFFF: f.color_name = CN_CYAN;
            24'hFFFF00: f.color_name = CN_YELLOW;
            24'hFF00FF: f.color_name = CN_MAGENTA;
            default:    f.color_name = CN_NONE;
        endcase
        return f;
    endfunction

    task automatic check_field(input string label, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, exp_v, act_v);
            fail_total++;
        end
    endtask

    // Compare result transfers against the oldest prediction, then record new pixels
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_res.valid && i_res.ready) begin
                if (color_forms_q.size() == 0) begin
                    $display("%0t: result transfer with nothing expected, actual key %0d name %0d",
                             $time, i_res.key_percent, i_res.color_name);
                    fail_total++;
                end else begin
                    want = color_forms_q.pop_front();
                    check_field("red_tenths",      want.red_tenths,      i_res.red_tenths);
                    check_field("green_tenths",    want.green_tenths,    i_res.green_tenths);
                    check_field("blue_tenths",     want.blue_tenths,     i_res.blue_tenths);
                    check_field("red_percent",     want.red_percent,     i_res.red_percent);
                    check_field("green_percent",   want.green_percent,   i_res.green_percent);
                    check_field("blue_percent",    want.blue_percent,    i_res.blue_percent);
                    check_field("cyan_percent",    want.cyan_percent,    i_res.cyan_percent);
                    check_field("magenta_percent", want.magenta_percent, i_res.magenta_percent);
                    check_field("yellow_percent",  want.yellow_percent,  i_res.yellow_percent);
                    check_field("key_percent",     want.key_percent,     i_res.key_percent);
                    check_field("color_name",      want.color_name,      i_res.color_name);
                end
            end
            if (i_pix.valid && i_pix.ready) begin
                color_forms_q.push_back(predict_forms(i_pix.red, i_pix.green, i_pix.blue));
            end
        end
        o_pending    <= color_forms_q.size();
        o_fail_count <= fail_total;
    end

endmodule

@@ test/tb.sv @@
// Top of the converter testbench: clock, reset, pixel stimulus, result back-pressure, verdict.
`timescale 1ns / 100ps

module tb import r2c_pkg::*;;

    localparam int  RAND_PIXELS  = 850;
    localparam int  HOLD_AT      = 300;
    localparam int  HOLD_CYCLES  = 80;
    localparam int  DRAIN_CYCLES = 16;
    localparam real RUN_LIMIT_NS = 2_000_000.0;

    // Named colors, extremes, rounding ties and near-black inks
    localparam logic [23:0] DIRECTED_PIX [22] = '{
        24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF,
        24'h00FFFF, 24'hFFFF00, 24'hFF00FF, 24'h010101, 24'hFEFEFE,
        24'hFFFEFF, 24'h010000, 24'h000001, 24'h804020, 24'h7F8081,
        24'hC80101, 24'h01C803, 24'h020100, 24'h336699, 24'hAA55AA,
        24'h00FF01, 24'h7F7F7F
    };

    logic i_clk;
    logic i_rst_n;
    logic no_idle;
    int   fail_count;
    int   pending;
    int   drained;

    r2c_pix_if pix_ch ();
    r2c_res_if res_ch ();

    rgb_to_cmyk_converter u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_ch),
        .o_res   (res_ch)
    );

    r2c_color_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pix        (pix_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Offer one pixel after a random gap and hold it until the transfer
    task automatic send_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                              input logic [PIX_W-1:0] b);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            pix_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_ch.valid <= 1'b1;
        pix_ch.red   <= r;
        pix_ch.green <= g;
        pix_ch.blue  <= b;
        @(posedge i_clk);
        while (!pix_ch.ready) @(posedge i_clk);
    endtask

    function automatic logic [PIX_W-1:0] edge_channel();
        case ($urandom_range(0, 6))
            0:       return 8'd0;
            1:       return 8'd1;
            2:       return 8'd2;
            3:       return 8'd127;
            4:       return 8'd128;
            5:       return 8'd254;
            default: return 8'd255;
        endcase
    endfunction

    // Run limit
    initial begin
        #(RUN_LIMIT_NS);
        $display("TB_ERROR");
        $finish;
    end

    // Result side: random stalls, one long hold-off so the pipeline fills
    initial begin
        int hold;
        res_ch.ready <= 1'b0;
        drained = 0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (drained == HOLD_AT) begin
                hold = HOLD_CYCLES;
            end else begin
                hold = no_idle ? 0 : $urandom_range(0, 4);
            end
            if (hold > 0) begin
                res_ch.ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!res_ch.valid) @(posedge i_clk);
            drained++;
        end
    end

    // Pixel side and verdict
    initial begin
        logic [PIX_W-1:0] r, g, b;
        no_idle      = 1'b0;
        i_rst_n      <= 1'b0;
        pix_ch.valid <= 1'b0;
        pix_ch.red   <= '0;
        pix_ch.green <= '0;
        pix_ch.blue  <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED_PIX[k]) begin
            send_pixel(DIRECTED_PIX[k][23:16], DIRECTED_PIX[k][15:8], DIRECTED_PIX[k][7:0]);
        end

        for (int n = 0; n < RAND_PIXELS; n++) begin
            // Back-to-back stretches on both sides
            no_idle = (n >= 400 && n < 500) || (n >= 700 && n < 740);
            case ($urandom_range(0, 9))
                5: begin
                    r = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                    g = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                    b = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                end
                6: begin
                    r = edge_channel();
                    g = edge_channel();
                    b = edge_channel();
                end
                7: begin
                    // Near-gray
                    r = 8'($urandom_range(0, 255));
                    g = r ^ 8'($urandom_range(0, 3));
                    b = r ^ 8'($urandom_range(0, 3));
                end
                8: begin
                    // Dark pixels: small max, frequent rounding ties
                    r = 8'($urandom_range(0, 7));
                    g = 8'($urandom_range(0, 7));
                    b = 8'($urandom_range(0, 7));
                end
                9: begin
                    // Red and green equal, so two channels often share the max
                    r = 8'($urandom_range(0, 255));
                    g = r;
                    b = 8'($urandom_range(0, 255));
                end
                default: begin
                    r = 8'($urandom_range(0, 255));
                    g = 8'($urandom_range(0, 255));
                    b = 8'($urandom_range(0, 255));
                end
            endcase
            send_pixel(r, g, b);
        end
        pix_ch.valid <= 1'b0;
        no_idle = 1'b0;

        // Drain every expected result, then let the pipeline settle
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/r2c_pkg.sv
rtl/core/r2c_if.sv
rtl/core/rgb_to_cmyk_converter.sv
rtl/core/r2c_checker.sv
test/r2c_color_checker.sv
test/tb.sv
